// File: hw/rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared definitions for the text console character writer
// Screen geometry, cell store widths, action codes, register indexes and the
// packed command and result word types.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Screen geometry.
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELLS      = COLUMNS * ROWS;
    localparam int MOVE_CELLS = CELLS - COLUMNS;

    // Widths derived from the geometry.
    localparam int ADDR_W = $clog2(CELLS);
    localparam int POS_W  = ADDR_W + 1;
    localparam int COL_W  = (COLUMNS > 2) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int CELL_W = 16;

    // Fixed field widths of the ports.
    localparam int CURSOR_W = 11;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 1;

    // Character codes.
    localparam logic [7:0] CH_ERROR   = 8'h45;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // Action codes.
    localparam logic [1:0] ACT_PRINT    = 2'd0;
    localparam logic [1:0] ACT_PRINT_AT = 2'd1;
    localparam logic [1:0] ACT_READ     = 2'd2;
    localparam logic [1:0] ACT_CLEAR    = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_ATTR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_ATTR   = 1'b1;

    // Command word.
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] character;
        logic [7:0] column;
        logic [5:0] row;
        logic [7:0] attribute;
    } cmd_t;

    // Result word.
    typedef struct packed {
        logic [CURSOR_W-1:0] cursor_cell;
        logic [7:0]          cell_character;
        logic [7:0]          cell_attribute;
        logic                position_error;
    } res_t;

    // Access request from the sequencer to the cell store.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

// File: hw/rtl/tcw_cell_store.sv
// ----------------------------------------------------------------------------
// tcw_cell_store: character and attribute cell memory
// One write port and one read port; read data is registered, so it appears
// in the cycle after the read request.
// ----------------------------------------------------------------------------
module tcw_cell_store (
    input  logic                              clk,
    input  tcw_pkg::mem_req_t                 req,
    output logic [tcw_pkg::CELL_W-1:0]        rd_data
);

    logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELLS];
    logic [tcw_pkg::CELL_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/tcw_seq.sv
// ----------------------------------------------------------------------------
// tcw_seq: command sequencer of the text console
// Keeps the cursor, turns each command word into cell store accesses and
// walks the store for the reset clearing pass, screen clear and scrolling.
// ----------------------------------------------------------------------------
module tcw_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  tcw_pkg::cmd_t                 cmd,
    input  logic [7:0]                    default_attr,
    input  logic [7:0]                    error_attr,
    input  logic [tcw_pkg::CELL_W-1:0]    rd_data,
    output tcw_pkg::mem_req_t             mem_req,
    output logic                          busy,
    output logic                          done,
    output tcw_pkg::res_t                 result
);

    localparam int ADDR_W = tcw_pkg::ADDR_W;
    localparam int POS_W  = tcw_pkg::POS_W;
    localparam int COL_W  = tcw_pkg::COL_W;
    localparam int ROW_W  = tcw_pkg::ROW_W;

    // Sequencer states.
    localparam logic [2:0] ST_FILL   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_SCROLL = 3'd3;
    localparam logic [2:0] ST_BLANK  = 3'd4;

    localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(tcw_pkg::CELLS - 1);
    localparam logic [ADDR_W-1:0] MOVE_END   = ADDR_W'(tcw_pkg::MOVE_CELLS);
    localparam logic [ADDR_W-1:0] COLS_ADDR  = ADDR_W'(tcw_pkg::COLUMNS);
    localparam logic [POS_W-1:0]  COLS_POS   = POS_W'(tcw_pkg::COLUMNS);
    localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(tcw_pkg::COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROWS_ROW   = ROW_W'(tcw_pkg::ROWS);
    localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(tcw_pkg::ROWS - 1);

    logic [2:0]                  state_reg, state_next;
    logic [ADDR_W-1:0]           idx_reg, idx_next;
    logic [ADDR_W-1:0]           dst_reg, dst_next;
    logic                        pend_reg, pend_next;
    logic                        report_reg, report_next;
    logic [tcw_pkg::CELL_W-1:0]  fill_data_reg, fill_data_next;
    logic [ADDR_W-1:0]           cursor_reg, cursor_next;
    logic [ROW_W-1:0]            cur_row_reg, cur_row_next;
    logic [COL_W-1:0]            cur_col_reg, cur_col_next;
    logic                        done_reg, done_next;
    tcw_pkg::res_t               result_reg, result_next;

    // Decoded command position.
    logic                        col_ok;
    logic                        row_ok;
    logic                        off_screen;
    logic [ADDR_W-1:0]           given_idx;
    logic [ADDR_W-1:0]           p_idx;
    logic [ROW_W-1:0]            p_row;
    logic [COL_W-1:0]            p_col;
    logic [7:0]                  attr_eff;
    logic [POS_W-1:0]            n_pos;
    logic [ROW_W-1:0]            n_row;
    logic [COL_W-1:0]            n_col;

    // Position of a command: the given column and row, or the cursor.
    always_comb
    begin
        col_ok     = cmd.column < 8'(tcw_pkg::COLUMNS);
        row_ok     = cmd.row < 6'(tcw_pkg::ROWS);
        off_screen = !(col_ok && row_ok);
        given_idx  = ADDR_W'(cmd.row) * COLS_ADDR + ADDR_W'(cmd.column);
        attr_eff   = (cmd.attribute == 8'd0) ? default_attr : cmd.attribute;
        if (cmd.action == tcw_pkg::ACT_PRINT_AT)
        begin
            p_idx = given_idx;
            p_row = ROW_W'(cmd.row);
            p_col = COL_W'(cmd.column);
        end
        else
        begin
            p_idx = cursor_reg;
            p_row = cur_row_reg;
            p_col = cur_col_reg;
        end
        // New position after a newline or after one written cell.
        if (cmd.character == tcw_pkg::CH_NEWLINE)
        begin
            n_pos = POS_W'(p_idx) - POS_W'(p_col) + COLS_POS;
            n_row = p_row + ROW_W'(1);
            n_col = '0;
        end
        else if (p_col == LAST_COL)
        begin
            n_pos = POS_W'(p_idx) + POS_W'(1);
            n_row = p_row + ROW_W'(1);
            n_col = '0;
        end
        else
        begin
            n_pos = POS_W'(p_idx) + POS_W'(1);
            n_row = p_row;
            n_col = p_col + COL_W'(1);
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        dst_next       = dst_reg;
        pend_next      = pend_reg;
        report_next    = report_reg;
        fill_data_next = fill_data_reg;
        cursor_next    = cursor_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        mem_req        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd.action)
                        tcw_pkg::ACT_PRINT, tcw_pkg::ACT_PRINT_AT:
                        begin
                            if ((cmd.action == tcw_pkg::ACT_PRINT_AT) && off_screen)
                            begin
                                // Error marker in the last cell; cursor stays.
                                mem_req.we    = 1'b1;
                                mem_req.waddr = LAST_CELL;
                                mem_req.wdata = {error_attr, tcw_pkg::CH_ERROR};
                                done_next     = 1'b1;
                                result_next   = '{tcw_pkg::CURSOR_W'(cursor_reg),
                                                  8'd0, 8'd0, 1'b1};
                            end
                            else
                            begin
                                if (cmd.character != tcw_pkg::CH_NEWLINE)
                                begin
                                    mem_req.we    = 1'b1;
                                    mem_req.waddr = p_idx;
                                    mem_req.wdata = {attr_eff, cmd.character};
                                end
                                cur_col_next = n_col;
                                if (n_row == ROWS_ROW)
                                begin
                                    // Ran past the last row: scroll the store.
                                    cursor_next  = ADDR_W'(n_pos - COLS_POS);
                                    cur_row_next = LAST_ROW;
                                    idx_next     = '0;
                                    pend_next    = 1'b0;
                                    state_next   = ST_SCROLL;
                                end
                                else
                                begin
                                    cursor_next  = ADDR_W'(n_pos);
                                    cur_row_next = n_row;
                                    done_next    = 1'b1;
                                    result_next  = '{tcw_pkg::CURSOR_W'(n_pos),
                                                     8'd0, 8'd0, 1'b0};
                                end
                            end
                        end
                        tcw_pkg::ACT_READ:
                        begin
                            if (off_screen)
                            begin
                                done_next   = 1'b1;
                                result_next = '{tcw_pkg::CURSOR_W'(cursor_reg),
                                                8'd0, 8'd0, 1'b1};
                            end
                            else
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = given_idx;
                                state_next    = ST_READ;
                            end
                        end
                        tcw_pkg::ACT_CLEAR:
                        begin
                            fill_data_next = {default_attr, tcw_pkg::CH_SPACE};
                            idx_next       = '0;
                            report_next    = 1'b1;
                            state_next     = ST_FILL;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                // Read data of the requested cell is valid now.
                done_next   = 1'b1;
                result_next = '{tcw_pkg::CURSOR_W'(cursor_reg),
                                rd_data[7:0], rd_data[15:8], 1'b0};
                state_next  = ST_IDLE;
            end

            ST_FILL:
            begin
                // One cell per cycle for the reset pass and screen clear.
                mem_req.we    = 1'b1;
                mem_req.waddr = idx_reg;
                mem_req.wdata = fill_data_reg;
                if (idx_reg == LAST_CELL)
                begin
                    state_next  = ST_IDLE;
                    report_next = 1'b0;
                    if (report_reg)
                    begin
                        done_next   = 1'b1;
                        result_next = '{tcw_pkg::CURSOR_W'(cursor_reg),
                                        8'd0, 8'd0, 1'b0};
                    end
                end
                else
                begin
                    idx_next = idx_reg + ADDR_W'(1);
                end
            end

            ST_SCROLL:
            begin
                // Read one row ahead, write back the word read last cycle.
                if (pend_reg)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = dst_reg;
                    mem_req.wdata = rd_data;
                end
                if (idx_reg < MOVE_END)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = idx_reg + COLS_ADDR;
                    dst_next      = idx_reg;
                    pend_next     = 1'b1;
                    idx_next      = idx_reg + ADDR_W'(1);
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = ST_BLANK;
                end
            end

            ST_BLANK:
            begin
                // Zero the last row.
                mem_req.we    = 1'b1;
                mem_req.waddr = idx_reg;
                mem_req.wdata = '0;
                if (idx_reg == LAST_CELL)
                begin
                    state_next  = ST_IDLE;
                    done_next   = 1'b1;
                    result_next = '{tcw_pkg::CURSOR_W'(cursor_reg),
                                    8'd0, 8'd0, 1'b0};
                end
                else
                begin
                    idx_next = idx_reg + ADDR_W'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            report_reg    <= 1'b0;
            fill_data_reg <= '0;
            cursor_reg    <= '0;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            report_reg    <= report_next;
            fill_data_reg <= fill_data_next;
            cursor_reg    <= cursor_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            done_reg      <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        dst_reg    <= dst_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // The cursor index always matches its row and column.
    a_cursor_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg == ADDR_W'(cur_row_reg) * COLS_ADDR + ADDR_W'(cur_col_reg))
        else $error("cursor index out of step with row and column");

    // The cursor stays on the screen.
    a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_row_reg < ROWS_ROW) && (cur_col_reg <= LAST_COL))
        else $error("cursor left the screen");

    // Store writes stay inside the store.
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |-> (mem_req.waddr <= LAST_CELL))
        else $error("cell store write beyond the last cell");

    // An accepted command either reports at once or keeps the block busy.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted command neither reported nor in progress");

endmodule

// File: hw/rtl/text_console_char_writer.sv
// ----------------------------------------------------------------------------
// text_console_char_writer: text-mode console with cell store and cursor
// A print or error word reports in the cycle after accept and, unless the
// print scrolls, the next word may follow at once; a read reports once it has
// passed the read state and the done register. A scroll and a clear keep busy
// high while the sequencer walks every cell of the store once.
// After reset, busy stays high for a pass that zeroes the store; configuration
// writes are taken throughout. Results are never held.
// ----------------------------------------------------------------------------
module text_console_char_writer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  tcw_pkg::cmd_t                     cmd,
    output logic                              done,
    output tcw_pkg::res_t                     result,
    input  logic                              cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tcw_pkg::CFG_W-1:0]         cfg_data
);

    logic [7:0]                      default_attr_reg;
    logic [7:0]                      error_attr_reg;
    tcw_pkg::mem_req_t               mem_req;
    logic [tcw_pkg::CELL_W-1:0]      rd_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_attr_reg <= 8'd31;
            error_attr_reg   <= 8'd244;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tcw_pkg::REG_DEFAULT_ATTR:
                begin
                    default_attr_reg <= cfg_data;
                end
                tcw_pkg::REG_ERROR_ATTR:
                begin
                    error_attr_reg <= cfg_data;
                end
                default:
                begin
                    default_attr_reg <= default_attr_reg;
                end
            endcase
        end
    end

    // Command sequencer.
    tcw_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd          (cmd),
        .default_attr (default_attr_reg),
        .error_attr   (error_attr_reg),
        .rd_data      (rd_data),
        .mem_req      (mem_req),
        .busy         (busy),
        .done         (done),
        .result       (result)
    );

    // Cell store.
    tcw_cell_store u_store (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for text_console_char_writer
// A queue of command words and register writes feeds a clocked driver, which
// runs each accepted word through a behavioral copy of the console (cell
// store, cursor and attribute registers) and files the predicted result.
// A clocked monitor matches every done strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

    typedef enum logic { OP_WORD, OP_REG } op_kind_t;

    // One entry of the stimulus queue: a command word or a register write.
    typedef struct {
        op_kind_t                       kind;
        tcw_pkg::cmd_t                  word;
        logic [tcw_pkg::CFG_IDX_W-1:0]  reg_index;
        logic [tcw_pkg::CFG_W-1:0]      reg_value;
        int unsigned                    gap;
    } console_op_t;

    // A predicted result, stamped with the cycle of its acceptance.
    typedef struct {
        tcw_pkg::res_t  word;
        longint         accepted_at;
    } due_result_t;

    localparam int MAX_GAP     = 17;
    localparam int PHASE_WORDS = 330;

    // Clock, reset and block ports.
    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           start = 1'b0;
    logic                           busy;
    tcw_pkg::cmd_t                  cmd = '0;
    logic                           done;
    tcw_pkg::res_t                  result;
    logic                           cfg_we = 1'b0;
    logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tcw_pkg::CFG_W-1:0]      cfg_data = '0;

    // Stimulus and scoreboard storage.
    console_op_t  pending_ops[$];
    due_result_t  due_results[$];
    longint       cycle_count = 0;
    int unsigned  words_accepted = 0;
    int unsigned  words_answered = 0;
    int unsigned  fail_count = 0;
    int unsigned  idle_left = 0;
    int unsigned  word_gap = 0;
    int unsigned  stretch_left = 0;
    bit           stretch_busy = 1'b0;

    // Behavioral copy of the console state.
    logic [tcw_pkg::CELL_W-1:0]  screen_model [tcw_pkg::CELLS];
    int unsigned                 cursor_model = 0;
    logic [7:0]                  default_attr_model = 8'd31;
    logic [7:0]                  error_attr_model = 8'd244;

    text_console_char_writer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Writes a character or takes a newline at a cell index, scrolling when
    // the position runs off the end of the screen; returns the new position.
    function automatic int unsigned place_char(int unsigned pos, logic [7:0] ch,
                                               logic [7:0] attr);
        logic [7:0] use_attr;
        use_attr = (attr == 8'd0) ? default_attr_model : attr;
        if (ch == tcw_pkg::CH_NEWLINE)
        begin
            pos = (pos / tcw_pkg::COLUMNS + 1) * tcw_pkg::COLUMNS;
        end
        else
        begin
            screen_model[pos] = {use_attr, ch};
            pos = pos + 1;
        end
        if (pos >= tcw_pkg::CELLS)
        begin
            for (int i = 0; i < tcw_pkg::MOVE_CELLS; i++)
            begin
                screen_model[i] = screen_model[i + tcw_pkg::COLUMNS];
            end
            for (int i = tcw_pkg::MOVE_CELLS; i < tcw_pkg::CELLS; i++)
            begin
                screen_model[i] = '0;
            end
            pos = pos - tcw_pkg::COLUMNS;
        end
        return pos;
    endfunction

    // Applies one command word to the console copy and returns its result.
    function automatic tcw_pkg::res_t predict_console(tcw_pkg::cmd_t c);
        tcw_pkg::res_t  r;
        logic           off_screen;
        int unsigned    cell_idx;
        r = '0;
        off_screen = (c.column >= tcw_pkg::COLUMNS) || (c.row >= tcw_pkg::ROWS);
        cell_idx = c.row * tcw_pkg::COLUMNS + c.column;
        case (c.action)
            tcw_pkg::ACT_PRINT:
            begin
                cursor_model = place_char(cursor_model, c.character, c.attribute);
            end
            tcw_pkg::ACT_PRINT_AT:
            begin
                if (off_screen)
                begin
                    screen_model[tcw_pkg::CELLS - 1] = {error_attr_model,
                                                        tcw_pkg::CH_ERROR};
                    r.position_error = 1'b1;
                end
                else
                begin
                    cursor_model = place_char(cell_idx, c.character, c.attribute);
                end
            end
            tcw_pkg::ACT_READ:
            begin
                if (off_screen)
                begin
                    r.position_error = 1'b1;
                end
                else
                begin
                    r.cell_character = screen_model[cell_idx][7:0];
                    r.cell_attribute = screen_model[cell_idx][15:8];
                end
            end
            default:
            begin
                for (int i = 0; i < tcw_pkg::CELLS; i++)
                begin
                    screen_model[i] = {default_attr_model, tcw_pkg::CH_SPACE};
                end
            end
        endcase
        r.cursor_cell = cursor_model[tcw_pkg::CURSOR_W-1:0];
        return r;
    endfunction

    // Driver: presents queued words, and register writes once the block is idle.
    always @(posedge clk)
    begin : drive_proc
        console_op_t  op;
        due_result_t  due;
        logic         next_start;
        logic         next_we;
        logic         taken;
        if (!rst_n)
        begin
            start <= 1'b0;
            cfg_we <= 1'b0;
        end
        else
        begin
            next_start = start;
            next_we = 1'b0;
            taken = start && !busy;
            if (taken)
            begin
                due.word = predict_console(cmd);
                due.accepted_at = cycle_count;
                due_results.push_back(due);
                words_accepted <= words_accepted + 1;
                next_start = 1'b0;
                idle_left = word_gap;
            end
            if (!next_start)
            begin
                if (idle_left != 0)
                begin
                    idle_left--;
                end
                else if (pending_ops.size() != 0)
                begin
                    op = pending_ops[0];
                    if (op.kind == OP_WORD)
                    begin
                        void'(pending_ops.pop_front());
                        cmd <= op.word;
                        word_gap = op.gap;
                        next_start = 1'b1;
                    end
                    else if (!taken && !busy && words_accepted == words_answered)
                    begin
                        void'(pending_ops.pop_front());
                        cfg_index <= op.reg_index;
                        cfg_data <= op.reg_value;
                        next_we = 1'b1;
                        if (op.reg_index == tcw_pkg::REG_DEFAULT_ATTR)
                        begin
                            default_attr_model = op.reg_value;
                        end
                        else
                        begin
                            error_attr_model = op.reg_value;
                        end
                    end
                end
            end
            start <= next_start;
            cfg_we <= next_we;
        end
    end

    task automatic check_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    // Monitor: every strobed result must match the oldest outstanding word.
    always @(posedge clk)
    begin : watch_proc
        due_result_t  due;
        if (rst_n && done)
        begin
            if (due_results.size() == 0 || due_results[0].accepted_at >= cycle_count)
            begin
                fail_count++;
                $display("%0t: result word with nothing outstanding, expected none, got %p",
                         $time, result);
            end
            else
            begin
                due = due_results.pop_front();
                check_field("cursor_cell", due.word.cursor_cell, result.cursor_cell);
                check_field("cell_character", due.word.cell_character,
                            result.cell_character);
                check_field("cell_attribute", due.word.cell_attribute,
                            result.cell_attribute);
                check_field("position_error", due.word.position_error,
                            result.position_error);
                words_answered <= words_answered + 1;
            end
        end
    end

    // Queues one command word; the sender picks each stretch at random to be a
    // burst with no gaps or a stretch of random gaps.
    task automatic add_word(logic [1:0] action, logic [7:0] ch, logic [7:0] col,
                            logic [5:0] row, logic [7:0] attr);
        console_op_t op;
        if (stretch_left == 0)
        begin
            stretch_busy = ($urandom_range(0, 99) < 30);
            stretch_left = $urandom_range(10, 60);
        end
        stretch_left--;
        op.kind = OP_WORD;
        op.word.action = action;
        op.word.character = ch;
        op.word.column = col;
        op.word.row = row;
        op.word.attribute = attr;
        op.reg_index = '0;
        op.reg_value = '0;
        op.gap = stretch_busy ? 0 : $urandom_range(0, MAX_GAP);
        pending_ops.push_back(op);
    endtask

    task automatic add_setting(logic [7:0] dflt, logic [7:0] errm);
        console_op_t op;
        op.kind = OP_REG;
        op.word = '0;
        op.gap = 0;
        op.reg_index = tcw_pkg::REG_DEFAULT_ATTR;
        op.reg_value = dflt;
        pending_ops.push_back(op);
        op.reg_index = tcw_pkg::REG_ERROR_ATTR;
        op.reg_value = errm;
        pending_ops.push_back(op);
    endtask

    // Random word: mostly on-screen prints and reads, a few off-screen
    // positions, rare newlines and rarer clears to keep scroll time bounded.
    task automatic add_random_word();
        int unsigned  pick;
        logic [7:0]   ch;
        logic [7:0]   col;
        logic [5:0]   row;
        logic [7:0]   attr;
        pick = $urandom_range(0, 99);
        ch = 8'($urandom_range(0, 255));
        col = 8'($urandom_range(0, 255));
        row = 6'($urandom_range(0, 63));
        attr = ($urandom_range(0, 99) < 15) ? 8'd0 : 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 4)
        begin
            ch = tcw_pkg::CH_NEWLINE;
        end
        if ($urandom_range(0, 99) < 85)
        begin
            col = 8'($urandom_range(0, tcw_pkg::COLUMNS - 1));
            row = 6'($urandom_range(0, tcw_pkg::ROWS - 1));
        end
        if (pick < 45)
        begin
            add_word(tcw_pkg::ACT_PRINT, ch, col, row, attr);
        end
        else if (pick < 75)
        begin
            add_word(tcw_pkg::ACT_PRINT_AT, ch, col, row, attr);
        end
        else if (pick < 97)
        begin
            add_word(tcw_pkg::ACT_READ, ch, col, row, attr);
        end
        else
        begin
            add_word(tcw_pkg::ACT_CLEAR, ch, col, row, attr);
        end
    endtask

    // Reset, stimulus and final verdict.
    initial
    begin
        for (int i = 0; i < tcw_pkg::CELLS; i++)
        begin
            screen_model[i] = '0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed words under the reset values of the registers.
        add_word(tcw_pkg::ACT_READ, 8'h00, 8'd0, 6'd0, 8'h00);
        add_word(tcw_pkg::ACT_PRINT, 8'h41, 8'd0, 6'd0, 8'h00);
        add_word(tcw_pkg::ACT_PRINT, 8'hFF, 8'd255, 6'd63, 8'hFF);
        add_word(tcw_pkg::ACT_READ, 8'h00, 8'd0, 6'd0, 8'h00);
        add_word(tcw_pkg::ACT_READ, 8'hFF, 8'd1, 6'd0, 8'hFF);
        // Last cell written: the screen scrolls.
        add_word(tcw_pkg::ACT_PRINT_AT, 8'h5A, 8'(tcw_pkg::COLUMNS - 1),
                 6'(tcw_pkg::ROWS - 1), 8'h80);
        add_word(tcw_pkg::ACT_READ, 8'h00, 8'(tcw_pkg::COLUMNS - 1),
                 6'(tcw_pkg::ROWS - 2), 8'h00);
        add_word(tcw_pkg::ACT_READ, 8'h00, 8'(tcw_pkg::COLUMNS - 1),
                 6'(tcw_pkg::ROWS - 1), 8'h00);
        // Off-screen prints and reads.
        add_word(tcw_pkg::ACT_PRINT_AT, 8'h31, 8'(tcw_pkg::COLUMNS), 6'd0, 8'h07);
        add_word(tcw_pkg::ACT_READ, 8'h00, 8'(tcw_pkg::COLUMNS - 1),
                 6'(tcw_pkg::ROWS - 1), 8'h00);
        add_word(tcw_pkg::ACT_PRINT_AT, 8'h32, 8'd0, 6'(tcw_pkg::ROWS), 8'h07);
        add_word(tcw_pkg::ACT_PRINT_AT, 8'h33, 8'd255, 6'd63, 8'h07);
        add_word(tcw_pkg::ACT_READ, 8'h00, 8'(tcw_pkg::COLUMNS), 6'd3, 8'h00);
        add_word(tcw_pkg::ACT_READ, 8'h00, 8'd3, 6'd63, 8'h00);
        // Newlines: on the last row, mid-screen, and placed on the last row.
        add_word(tcw_pkg::ACT_PRINT, tcw_pkg::CH_NEWLINE, 8'd0, 6'd0, 8'h00);
        add_word(tcw_pkg::ACT_PRINT_AT, tcw_pkg::CH_NEWLINE, 8'd5, 6'd3, 8'h00);
        add_word(tcw_pkg::ACT_PRINT_AT, tcw_pkg::CH_NEWLINE, 8'd10,
                 6'(tcw_pkg::ROWS - 1), 8'h00);
        add_word(tcw_pkg::ACT_PRINT_AT, 8'h00, 8'd0, 6'd0, 8'h01);
        // Clear keeps the cursor and fills with spaces.
        add_word(tcw_pkg::ACT_CLEAR, 8'hAA, 8'd200, 6'd50, 8'h55);
        add_word(tcw_pkg::ACT_READ, 8'h00, 8'd40, 6'd12, 8'h00);
        // Print at the cursor wraps off the last cell.
        add_word(tcw_pkg::ACT_PRINT_AT, 8'h71, 8'(tcw_pkg::COLUMNS - 2),
                 6'(tcw_pkg::ROWS - 1), 8'h00);
        add_word(tcw_pkg::ACT_PRINT, 8'h72, 8'd0, 6'd0, 8'h00);
        add_word(tcw_pkg::ACT_READ, 8'h00, 8'(tcw_pkg::COLUMNS - 1),
                 6'(tcw_pkg::ROWS - 2), 8'h00);
        add_word(tcw_pkg::ACT_READ, 8'h00, 8'(tcw_pkg::COLUMNS - 2),
                 6'(tcw_pkg::ROWS - 2), 8'h00);

        // Random phases under several register settings.
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: add_setting(8'h00, 8'hFF);
                1: add_setting(8'hFF, 8'h00);
                3: add_setting(8'd31, 8'd244);
                default: add_setting(8'($urandom_range(0, 255)),
                                     8'($urandom_range(0, 255)));
            endcase
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                add_random_word();
            end
        end

        while (pending_ops.size() != 0 || start || due_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (tcw_pkg::CELLS + 100) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog: covers every word being a full scroll plus the longest gaps.
    initial
    begin
        #(400_000_000);
        $display("FAIL");
        $finish;
    end

endmodule
